// ----- rtl/keyed_record_table_macros.svh -----
// Assertion macros for the keyed record table checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef KEYED_RECORD_TABLE_MACROS_SVH
`define KEYED_RECORD_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/krt_pkg.sv -----
// Shared types and constants for the keyed record table.
// No dependencies; used by keyed_record_table, krt_checker and the testbench.
`timescale 1ns / 1ps

package krt_pkg;

   // default number of stored keys
   localparam int CAPACITY_DEF = 64;

   localparam int KEY_W   = 31;
   localparam int COUNT_W = 7;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_LOAD   = 2'd2,
      OP_REMOVE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_DONE = 2'd0,
      STAT_DUP  = 2'd1,
      STAT_MISS = 2'd2,
      STAT_FULL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [KEY_W-1:0]  key;
   } req_beat_type;

   typedef struct packed {
      status_type          status;
      logic                hit;
      logic [COUNT_W-1:0]  count;
   } rsp_beat_type;

endpackage

// ----- rtl/krt_key_ram.sv -----
// Simple dual-port key memory: one write port, one registered read port.
// Depends on nothing; instantiated by keyed_record_table.
`timescale 1ns / 1ps

module krt_key_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 31
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // register the read data
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/keyed_record_table.sv -----
// Top level of the keyed record table: control sequencer and response register.
// Depends on krt_pkg and krt_key_ram.
`timescale 1ns / 1ps
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  req_data (opcode, key)
//   rsp       out        rsp_valid / rsp_stall  rsp_data (status, hit, count)
//
// One item at a time. The time from acceptance to the next acceptance grows
// with the number of stored keys, for every opcode, and a stalled response
// can hold it further. It is set by the key memory's single read port: the
// search reads one entry a cycle, and a remove compacts the entries after the
// match, reading and writing back one entry a cycle.
// Reset clears the state, the entry count and the response valid flag only;
// entries at or above the count are never used, so no clearing pass is run.
// A waiting response holds in its register while a new request is taken.

module keyed_record_table #(
   parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  krt_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output krt_pkg::rsp_beat_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   krt_pkg::state_type          state_ff, state_in;
   krt_pkg::opcode_type         op_ff, op_in;
   logic [krt_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        hit_ff, hit_in;
   krt_pkg::status_type         status_ff, status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   krt_pkg::rsp_beat_type       rsp_data_ff, rsp_data_in;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [krt_pkg::KEY_W-1:0]   wr_data;
   logic [AW-1:0]               rd_addr;
   logic [krt_pkg::KEY_W-1:0]   rd_data;

   logic                        req_take;
   logic                        table_full;

   krt_key_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (krt_pkg::KEY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != krt_pkg::ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign table_full = (count_ff == CW'(CAPACITY));
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= krt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and response payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sequence search, update, compaction and response
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      // drop the held response once taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data;
      rd_addr      = idx_ff;

      case (state_ff)
         krt_pkg::ST_IDLE: begin
            if (req_take) begin
               op_in   = req_data.opcode;
               key_in  = req_data.key;
               idx_in  = '0;
               hit_in  = 1'b0;
               rd_addr = '0;
               if (count_ff == '0) begin
                  state_in = krt_pkg::ST_DECIDE;
               end else begin
                  state_in = krt_pkg::ST_SEARCH;
               end
            end
         end

         krt_pkg::ST_SEARCH: begin
            // compare the entry read last cycle, advance on a miss
            if (rd_data == key_ff) begin
               hit_in   = 1'b1;
               state_in = krt_pkg::ST_DECIDE;
            end else if (CW'(idx_ff) + CW'(1) == count_ff) begin
               state_in = krt_pkg::ST_DECIDE;
            end else begin
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(1);
            end
         end

         krt_pkg::ST_DECIDE: begin
            state_in = krt_pkg::ST_FINISH;
            case (op_ff)
               krt_pkg::OP_LOOKUP: begin
                  status_in = hit_ff ? krt_pkg::STAT_DONE : krt_pkg::STAT_MISS;
               end
               krt_pkg::OP_INSERT, krt_pkg::OP_LOAD: begin
                  if (op_ff == krt_pkg::OP_INSERT && hit_ff) begin
                     status_in = krt_pkg::STAT_DUP;
                  end else if (table_full) begin
                     status_in = krt_pkg::STAT_FULL;
                  end else begin
                     // append at the end of the table
                     wr_en     = 1'b1;
                     wr_addr   = AW'(count_ff);
                     wr_data   = key_ff;
                     count_in  = count_ff + CW'(1);
                     status_in = krt_pkg::STAT_DONE;
                  end
               end
               krt_pkg::OP_REMOVE: begin
                  if (!hit_ff) begin
                     status_in = krt_pkg::STAT_MISS;
                  end else begin
                     status_in = krt_pkg::STAT_DONE;
                     if (CW'(idx_ff) + CW'(1) < count_ff) begin
                        rd_addr  = idx_ff + AW'(1);
                        state_in = krt_pkg::ST_SHIFT;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
               end
               default: begin
                  status_in = krt_pkg::STAT_DONE;
               end
            endcase
         end

         krt_pkg::ST_SHIFT: begin
            // move the next entry down one place
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            if (CW'(idx_ff) + CW'(2) < count_ff) begin
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(2);
            end else begin
               count_in = count_ff - CW'(1);
               state_in = krt_pkg::ST_FINISH;
            end
         end

         krt_pkg::ST_FINISH: begin
            // load the response once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = status_ff;
               rsp_data_in.hit    = hit_ff;
               rsp_data_in.count  = krt_pkg::COUNT_W'(count_ff);
               state_in           = krt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = krt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/krt_checker.sv -----
// Port-level checks for the keyed record table, bound to the top level.
// Depends on krt_pkg and keyed_record_table_macros.svh.
`timescale 1ns / 1ps
`include "keyed_record_table_macros.svh"

module krt_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input krt_pkg::rsp_beat_type rsp_data
);

   // hold a stalled response beat
   `KRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp beat dropped")
   `KRT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data), "rsp beat changed")

   // one item at a time: an accepted request closes the input
   `KRT_ASSERT_NEXT(a_busy, clock, reset, req_valid && !req_stall, req_stall, "second req taken early")

   // no response can be ready right after reset, and the input is open
   `KRT_ASSERT_NOW(a_reset_quiet, clock, reset, $past(reset), !rsp_valid && !req_stall, "bad state after reset")

endmodule

bind keyed_record_table krt_checker u_krt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- sim/keyed_record_table_test.sv -----
// Self-checking testbench for keyed_record_table: random and directed table operations.
// Depends on krt_pkg and the keyed_record_table RTL; predicts each response in-line.
`timescale 1ns / 1ps

module keyed_record_table_test;

   localparam int TABLE_DEPTH   = krt_pkg::CAPACITY_DEF;
   localparam int KEY_W         = krt_pkg::KEY_W;
   localparam int COUNT_W       = krt_pkg::COUNT_W;
   localparam int RANDOM_ITEMS  = 1900;
   localparam int KEY_POOL      = 48;
   localparam int TAIL_ITEMS    = 150;
   localparam int DRAIN_EVERY   = 400;
   localparam int SETTLE_CYCLES = 300;
   localparam int MAX_PRINTS    = 50;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   krt_pkg::req_beat_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   krt_pkg::rsp_beat_type rsp_data;

   // stimulus, prediction and scoreboard state
   krt_pkg::req_beat_type pending_req[$];
   krt_pkg::rsp_beat_type expected_rsp[$];
   logic [KEY_W-1:0]      stored_keys[$];
   logic [KEY_W-1:0]      key_pool[KEY_POOL];
   int                    n_total = 0;
   bit                    gen_done = 1'b0;
   int                    n_accepted = 0;
   int                    n_checked = 0;
   int                    mismatch_count = 0;
   bit                    quiet_tail = 1'b0;

   // driver-side pacing
   int send_gap = 0;
   int send_rate = 0;
   int send_cycle = 0;

   // monitor-side pacing
   int                    stall_left = 0;
   int                    stall_rate = 0;
   int                    stall_cycle = 0;
   krt_pkg::rsp_beat_type due_rsp;

   keyed_record_table #(.CAPACITY(TABLE_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // print one line per failure, up to a cap, and count all of them
   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("mismatch at response %0d: %s got %0d expected %0d",
                  n_checked, what, got, want);
   endtask

   // apply one operation to the shadow table and return its response
   function automatic krt_pkg::rsp_beat_type apply_table_op(krt_pkg::req_beat_type beat);
      krt_pkg::rsp_beat_type r;
      int                    pos;
      pos = -1;
      for (int i = 0; i < stored_keys.size(); i++)
         if (pos < 0 && stored_keys[i] == beat.key) pos = i;
      r.hit    = (pos >= 0);
      r.status = krt_pkg::STAT_DONE;
      case (beat.opcode)
         krt_pkg::OP_LOOKUP: begin
            if (!r.hit) r.status = krt_pkg::STAT_MISS;
         end
         krt_pkg::OP_INSERT, krt_pkg::OP_LOAD: begin
            if (beat.opcode == krt_pkg::OP_INSERT && r.hit) r.status = krt_pkg::STAT_DUP;
            else if (stored_keys.size() >= TABLE_DEPTH) r.status = krt_pkg::STAT_FULL;
            else stored_keys.push_back(beat.key);
         end
         default: begin
            if (!r.hit) r.status = krt_pkg::STAT_MISS;
            else stored_keys.delete(pos);
         end
      endcase
      r.count = COUNT_W'(stored_keys.size());
      return r;
   endfunction

   task automatic queue_item(krt_pkg::opcode_type op, logic [KEY_W-1:0] key);
      krt_pkg::req_beat_type b;
      b.opcode = op;
      b.key    = key;
      pending_req.push_back(b);
   endtask

   // keys from a small pool with probability pool_pct percent, else random, so that hits can be common
   function automatic logic [KEY_W-1:0] pick_key(int pool_pct);
      if ($urandom_range(0, 99) < pool_pct)
         return key_pool[$urandom_range(0, KEY_POOL - 1)];
      return KEY_W'($urandom);
   endfunction

   // reset: assert at the start, then release once
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // fill the stimulus queue
   initial begin : build_stimulus
      logic [KEY_W-1:0] last_key;
      int               n;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = KEY_W'($urandom);

      // directed: empty table, key extremes, duplicates, removal down to empty
      queue_item(krt_pkg::OP_LOOKUP, '0);
      queue_item(krt_pkg::OP_REMOVE, '1);
      queue_item(krt_pkg::OP_INSERT, '0);
      queue_item(krt_pkg::OP_INSERT, '1);
      queue_item(krt_pkg::OP_INSERT, '0);
      queue_item(krt_pkg::OP_LOAD,   '0);
      queue_item(krt_pkg::OP_LOOKUP, '0);
      queue_item(krt_pkg::OP_LOOKUP, '1);
      queue_item(krt_pkg::OP_LOOKUP, 31'h2AAA_AAAA);
      queue_item(krt_pkg::OP_REMOVE, '0);
      queue_item(krt_pkg::OP_LOOKUP, '0);
      queue_item(krt_pkg::OP_REMOVE, '0);
      queue_item(krt_pkg::OP_LOOKUP, '0);
      queue_item(krt_pkg::OP_REMOVE, '0);
      queue_item(krt_pkg::OP_INSERT, 31'h5555_5555);
      queue_item(krt_pkg::OP_REMOVE, '1);
      queue_item(krt_pkg::OP_REMOVE, 31'h5555_5555);
      queue_item(krt_pkg::OP_LOAD,   31'h2AAA_AAAA);
      queue_item(krt_pkg::OP_LOOKUP, 31'h2AAA_AAAA);
      queue_item(krt_pkg::OP_REMOVE, 31'h2AAA_AAAA);

      // random segments: fill to full, drain, mixed traffic, noise
      n = pending_req.size() + RANDOM_ITEMS;
      while (pending_req.size() < n) begin
         case ((pending_req.size() < 40) ? 0 : $urandom_range(0, 9))
            0, 1: begin
               last_key = key_pool[0];
               repeat (70) begin
                  last_key = pick_key(97);
                  queue_item(($urandom_range(0, 3) == 0) ? krt_pkg::OP_INSERT
                             : krt_pkg::OP_LOAD, last_key);
               end
               // at full: duplicate check ahead of the full check, then full refusals
               queue_item(krt_pkg::OP_INSERT, last_key);
               queue_item(krt_pkg::OP_INSERT, pick_key(0));
               queue_item(krt_pkg::OP_LOAD, last_key);
               queue_item(krt_pkg::OP_LOOKUP, last_key);
               queue_item(krt_pkg::OP_LOOKUP, pick_key(50));
            end
            2, 3: begin
               repeat (80)
                  queue_item(($urandom_range(0, 7) == 0) ? krt_pkg::OP_LOOKUP
                             : krt_pkg::OP_REMOVE, pick_key(95));
            end
            9: begin
               repeat (20)
                  queue_item(($urandom_range(0, 7) == 0)
                             ? krt_pkg::opcode_type'($urandom_range(1, 2))
                             : (($urandom_range(0, 1) == 0) ? krt_pkg::OP_LOOKUP
                                : krt_pkg::OP_REMOVE),
                             pick_key(0));
            end
            default: begin
               repeat (40)
                  queue_item(krt_pkg::opcode_type'($urandom_range(0, 3)), pick_key(90));
            end
         endcase
      end
      n_total  = pending_req.size();
      gen_done = 1'b1;
   end

   // driver: present one beat at a time, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(apply_table_op(req_data));
            n_accepted++;
         end

         // re-pick the idle density now and then, zero included
         send_cycle++;
         if (send_cycle % 200 == 0)
            case ($urandom_range(0, 2))
               0: send_rate = 0;
               1: send_rate = 10;
               default: send_rate = 40;
            endcase

         // advance only when the slot is free; a stalled beat holds
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (n_accepted > 0 && n_accepted % DRAIN_EVERY == 0
                         && n_checked != n_accepted) begin
               // pause until every outstanding response has come back
               req_valid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               req_data  <= pending_req.pop_front();
               req_valid <= 1'b1;
               if (pending_req.size() > TAIL_ITEMS && send_rate > 0
                   && $urandom_range(0, 99) < send_rate)
                  send_gap = $urandom_range(1, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
         quiet_tail <= gen_done && (pending_req.size() <= TAIL_ITEMS);
      end
   end

   // monitor: check each accepted response against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         n_checked <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("response with nothing pending, count", rsp_data.count, -1);
            end else begin
               due_rsp = expected_rsp.pop_front();
               if (rsp_data.status !== due_rsp.status)
                  report_mismatch("status", int'(rsp_data.status), int'(due_rsp.status));
               if (rsp_data.hit !== due_rsp.hit)
                  report_mismatch("hit", rsp_data.hit, due_rsp.hit);
               if (rsp_data.count !== due_rsp.count)
                  report_mismatch("count", rsp_data.count, due_rsp.count);
            end
            n_checked <= n_checked + 1;
         end

         stall_cycle++;
         if (stall_cycle % 250 == 0)
            case ($urandom_range(0, 2))
               0: stall_rate = 0;
               1: stall_rate = 8;
               default: stall_rate = 30;
            endcase

         // stall in bursts, none near the end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && stall_rate > 0 && $urandom_range(0, 99) < stall_rate) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // end of run: all beats in, all responses back, then a quiet settle
   initial begin
      @(posedge clock);
      while (!(gen_done && n_accepted == n_total)) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch("responses never returned", 0, expected_rsp.size());
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
